// ----- rtl/core/dsrc_pkg.sv -----
// Package with the shared types, constants and coil pattern function of the stepper controller.
`timescale 1ns / 1ps

package dsrc_pkg;

  localparam logic [7:0] STOP_PERIOD = 8'd150;
  localparam logic [7:0] ACCEL_PERIOD_RST = 8'd35;
  localparam logic [7:0] LOW_TORQUE_RST = 8'd1;
  localparam logic [2:0] MAX_PHASE_RST = 3'd4;
  localparam logic [2:0] MIN_PHASE_RST = 3'd1;
  localparam logic [7:0] MAX_MAGNITUDE = 8'd127;
  localparam logic [7:0] PERIOD_BASE = 8'd128;

  typedef enum logic [2:0] {
    REG_ACCEL_PERIOD = 3'd0,
    REG_LOW_TORQUE   = 3'd1,
    REG_ADAPTIVE     = 3'd2,
    REG_MAX_PHASE    = 3'd3,
    REG_MIN_PHASE    = 3'd4,
    REG_RELEASE      = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    CMD_TICK      = 1'b0,
    CMD_SET_SPEED = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [7:0] accel_period;
    logic [7:0] low_torque_speed;
    logic       adaptive_torque;
    logic [2:0] max_phase;
    logic [2:0] min_phase;
    logic       release_when_stopped;
  } cfg_t;

  function automatic logic [3:0] coil_pattern(input logic [2:0] ph, input logic single);
    logic [3:0] pat;
    pat = 4'b0000;
    case (ph)
      3'd1: pat = single ? 4'b0001 : 4'b0011;
      3'd2: pat = single ? 4'b0010 : 4'b0110;
      3'd3: pat = single ? 4'b0100 : 4'b1100;
      3'd4: pat = single ? 4'b1000 : 4'b1001;
      default: pat = 4'b0000;
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/core/dsrc_cfg.sv -----
// Configuration register file of the stepper controller.
`timescale 1ns / 1ps

module dsrc_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [7:0]    cfg_wdata,
  output dsrc_pkg::cfg_t cfg_o
);

  dsrc_pkg::cfg_t cfg_r;
  dsrc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (dsrc_pkg::cfg_reg_t'(cfg_addr))
        dsrc_pkg::REG_ACCEL_PERIOD: cfg_nxt.accel_period = cfg_wdata;
        dsrc_pkg::REG_LOW_TORQUE:   cfg_nxt.low_torque_speed = cfg_wdata;
        dsrc_pkg::REG_ADAPTIVE:     cfg_nxt.adaptive_torque = cfg_wdata[0];
        dsrc_pkg::REG_MAX_PHASE: begin
          if (cfg_wdata[2:0] >= cfg_r.min_phase) begin
            cfg_nxt.max_phase = cfg_wdata[2:0];
          end
        end
        dsrc_pkg::REG_MIN_PHASE: begin
          if (cfg_wdata[2:0] <= cfg_r.max_phase) begin
            cfg_nxt.min_phase = cfg_wdata[2:0];
          end
        end
        dsrc_pkg::REG_RELEASE:      cfg_nxt.release_when_stopped = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_period         <= dsrc_pkg::ACCEL_PERIOD_RST;
      cfg_r.low_torque_speed     <= dsrc_pkg::LOW_TORQUE_RST;
      cfg_r.adaptive_torque      <= 1'b0;
      cfg_r.max_phase            <= dsrc_pkg::MAX_PHASE_RST;
      cfg_r.min_phase            <= dsrc_pkg::MIN_PHASE_RST;
      cfg_r.release_when_stopped <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ----- rtl/core/dsrc_motor.sv -----
// Per-motor speed, ramp and phase state and its update logic.
`timescale 1ns / 1ps

module dsrc_motor (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              set_en,
  input  logic              tick_en,
  input  logic signed [7:0] speed,
  input  dsrc_pkg::cfg_t    cfg,
  output logic [3:0]        pattern_o,
  output logic              stopped_o
);

  logic [7:0] cur_r, cur_nxt;
  logic [7:0] want_r, want_nxt;
  logic [7:0] tgt_r, tgt_nxt;
  logic [7:0] step_r, step_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic       dir_now_r, dir_now_nxt;
  logic       dir_tgt_r, dir_tgt_nxt;
  logic       single_r, single_nxt;

  logic       dir_set;
  logic [7:0] speed_u;
  logic [7:0] mag;
  logic [7:0] per;
  logic [7:0] step_dec;
  logic [7:0] acc_dec;
  logic [2:0] phase_adv;

  always_comb begin
    speed_u = speed;
    dir_set = !speed[7] && (speed_u != 8'd0);
    mag = speed[7] ? (8'd0 - speed_u) : speed_u;
    if (mag > dsrc_pkg::MAX_MAGNITUDE) begin
      mag = dsrc_pkg::MAX_MAGNITUDE;
    end
    per = (mag == 8'd0) ? dsrc_pkg::STOP_PERIOD : (dsrc_pkg::PERIOD_BASE - mag);
  end

  always_comb begin
    if (dir_now_r) begin
      phase_adv = (phase_r == cfg.max_phase) ? cfg.min_phase : (phase_r + 3'd1);
    end else begin
      phase_adv = (phase_r == cfg.min_phase) ? cfg.max_phase : (phase_r - 3'd1);
    end
  end

  always_comb begin
    cur_nxt     = cur_r;
    want_nxt    = want_r;
    tgt_nxt     = tgt_r;
    step_nxt    = step_r;
    acc_nxt     = acc_r;
    phase_nxt   = phase_r;
    dir_now_nxt = dir_now_r;
    dir_tgt_nxt = dir_tgt_r;
    single_nxt  = single_r;
    step_dec    = step_r - 8'd1;
    acc_dec     = acc_r - 8'd1;
    if (set_en) begin
      dir_tgt_nxt = dir_set;
      tgt_nxt     = per;
      want_nxt    = (dir_now_r == dir_set) ? per : dsrc_pkg::STOP_PERIOD;
    end else if (tick_en) begin
      step_nxt = step_dec;
      if (step_dec == 8'd0) begin
        step_nxt = cur_r;
        if (cur_r != dsrc_pkg::STOP_PERIOD) begin
          phase_nxt = phase_adv;
        end else if (tgt_r != dsrc_pkg::STOP_PERIOD) begin
          dir_now_nxt = dir_tgt_r;
          want_nxt    = tgt_r;
        end
      end
      if (cur_r != want_nxt) begin
        acc_nxt = acc_dec;
        if (acc_dec == 8'd0) begin
          cur_nxt = (cur_r > want_nxt) ? (cur_r - 8'd1) : (cur_r + 8'd1);
          acc_nxt = cfg.accel_period;
        end
      end
      single_nxt = cfg.adaptive_torque && (cur_nxt < cfg.low_torque_speed);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= dsrc_pkg::STOP_PERIOD;
      want_r    <= dsrc_pkg::STOP_PERIOD;
      tgt_r     <= dsrc_pkg::STOP_PERIOD;
      step_r    <= 8'd1;
      acc_r     <= 8'd1;
      phase_r   <= 3'd4;
      dir_now_r <= 1'b1;
      dir_tgt_r <= 1'b1;
      single_r  <= 1'b0;
    end else begin
      cur_r     <= cur_nxt;
      want_r    <= want_nxt;
      tgt_r     <= tgt_nxt;
      step_r    <= step_nxt;
      acc_r     <= acc_nxt;
      phase_r   <= phase_nxt;
      dir_now_r <= dir_now_nxt;
      dir_tgt_r <= dir_tgt_nxt;
      single_r  <= single_nxt;
    end
  end

  assign pattern_o = dsrc_pkg::coil_pattern(phase_nxt, single_nxt);
  assign stopped_o = (cur_nxt == dsrc_pkg::STOP_PERIOD);

`ifndef ASSERT_OFF
  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != 8'd0)
    else $error("step countdown reached zero while idle");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !tick_en |=> $stable(phase_r))
    else $error("phase moved without a tick");

  a_period_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cur_r != $past(cur_r))) |->
      ((cur_r == $past(cur_r) + 8'd1) || (cur_r == $past(cur_r) - 8'd1)))
    else $error("current period jumped by more than one");
`endif

endmodule

// ----- rtl/core/dual_stepper_ramp_controller_top.sv -----
// A tick word's coil drive word is registered and valid in the cycle after the word is accepted.
// Throughput: one input word per cycle; all state updates in a single combinational pass.
// Input is stalled only while the output register holds a word that is not taken.
// Set-speed words update state and produce no output word.
// Reset is synchronous, active low: both motors stopped at phase 4, registers at defaults.
`timescale 1ns / 1ps

module dual_stepper_ramp_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // speed_a [7:0], speed_b [15:8]
  input  logic        in_tuser,   // command [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // coil_drive [7:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  dsrc_pkg::cfg_t cfg;
  logic           in_fire;
  logic           set_en;
  logic           tick_en;
  logic [3:0]     pat_a;
  logic [3:0]     pat_b;
  logic [3:0]     pat_a_rev;
  logic           stop_a;
  logic           stop_b;
  logic [7:0]     coil_drive;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_data_r, out_data_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign set_en    = in_fire && (dsrc_pkg::cmd_t'(in_tuser) == dsrc_pkg::CMD_SET_SPEED);
  assign tick_en   = in_fire && (dsrc_pkg::cmd_t'(in_tuser) == dsrc_pkg::CMD_TICK);

  dsrc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  dsrc_motor u_motor_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .set_en    (set_en),
    .tick_en   (tick_en),
    .speed     (in_tdata[7:0]),
    .cfg       (cfg),
    .pattern_o (pat_a),
    .stopped_o (stop_a)
  );

  dsrc_motor u_motor_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .set_en    (set_en),
    .tick_en   (tick_en),
    .speed     (in_tdata[15:8]),
    .cfg       (cfg),
    .pattern_o (pat_b),
    .stopped_o (stop_b)
  );

  // Motor A is wired with its coil order reversed.
  assign pat_a_rev  = {pat_a[0], pat_a[1], pat_a[2], pat_a[3]};
  assign coil_drive = (cfg.release_when_stopped && stop_a && stop_b) ? 8'd0
                                                                     : {pat_b, pat_a_rev};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (tick_en) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = coil_drive;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && !in_tuser))
    else $error("output word without an accepted tick");

  a_set_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser && !out_tvalid) |=> !out_tvalid)
    else $error("set-speed word produced an output word");
`endif

endmodule

// ----- verif/dual_stepper_ramp_controller_checker.sv -----
// Checker that mirrors both motors of the stepper controller and compares every coil drive word.
`timescale 1ns / 1ps

module dual_stepper_ramp_controller_checker
  import dsrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  output int          fail_count,
  output int          pending
);

  cfg_t       regs;
  logic [7:0] cur_per   [2];
  logic [7:0] want_per  [2];
  logic [7:0] tgt_per   [2];
  logic [7:0] step_cnt  [2];
  logic [7:0] accel_cnt [2];
  logic [2:0] phase     [2];
  logic       dir_now   [2];
  logic       dir_tgt   [2];
  logic       one_coil  [2];
  logic [7:0] coil_drive_q [$];

  task automatic reset_motors();
    regs.accel_period         = ACCEL_PERIOD_RST;
    regs.low_torque_speed     = LOW_TORQUE_RST;
    regs.adaptive_torque      = 1'b0;
    regs.max_phase            = MAX_PHASE_RST;
    regs.min_phase            = MIN_PHASE_RST;
    regs.release_when_stopped = 1'b1;
    for (int m = 0; m < 2; m++) begin
      cur_per[m]   = STOP_PERIOD;
      want_per[m]  = STOP_PERIOD;
      tgt_per[m]   = STOP_PERIOD;
      step_cnt[m]  = 8'd1;
      accel_cnt[m] = 8'd1;
      phase[m]     = 3'd4;
      dir_now[m]   = 1'b1;
      dir_tgt[m]   = 1'b1;
      one_coil[m]  = 1'b0;
    end
    coil_drive_q.delete();
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [7:0] data);
    case (addr)
      REG_ACCEL_PERIOD: regs.accel_period = data;
      REG_LOW_TORQUE:   regs.low_torque_speed = data;
      REG_ADAPTIVE:     regs.adaptive_torque = data[0];
      REG_MAX_PHASE:    if (data[2:0] >= regs.min_phase) regs.max_phase = data[2:0];
      REG_MIN_PHASE:    if (data[2:0] <= regs.max_phase) regs.min_phase = data[2:0];
      REG_RELEASE:      regs.release_when_stopped = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_speed(input int m, input logic signed [7:0] s);
    logic       fwd;
    logic [7:0] mag;
    logic [7:0] per;
    fwd = (s > 0);
    if (s == 8'sh80) mag = MAX_MAGNITUDE;
    else if (s < 0) mag = -s;
    else mag = s;
    per = (mag == 8'd0) ? STOP_PERIOD : PERIOD_BASE - mag;
    dir_tgt[m]  = fwd;
    tgt_per[m]  = per;
    want_per[m] = (dir_now[m] == fwd) ? per : STOP_PERIOD;
  endtask

  task automatic tick_motor(input int m);
    step_cnt[m] = step_cnt[m] - 8'd1;
    if (step_cnt[m] == 8'd0) begin
      step_cnt[m] = cur_per[m];
      if (cur_per[m] != STOP_PERIOD) begin
        if (dir_now[m]) begin
          phase[m] = (phase[m] == regs.max_phase) ? regs.min_phase : phase[m] + 3'd1;
        end else begin
          phase[m] = (phase[m] == regs.min_phase) ? regs.max_phase : phase[m] - 3'd1;
        end
      end else if (tgt_per[m] != STOP_PERIOD) begin
        dir_now[m]  = dir_tgt[m];
        want_per[m] = tgt_per[m];
      end
    end
    if (cur_per[m] != want_per[m]) begin
      accel_cnt[m] = accel_cnt[m] - 8'd1;
      if (accel_cnt[m] == 8'd0) begin
        cur_per[m]   = (cur_per[m] > want_per[m]) ? cur_per[m] - 8'd1 : cur_per[m] + 8'd1;
        accel_cnt[m] = regs.accel_period;
      end
    end
  endtask

  function automatic logic [3:0] coil_nibble(input logic [2:0] ph, input logic single);
    logic [7:0] rot;
    if (ph < 3'd1 || ph > 3'd4) return 4'b0000;
    if (single) return 4'b0001 << (ph - 3'd1);
    rot = 8'h33 << (ph - 3'd1);
    return rot[7:4];
  endfunction

  task automatic predict_tick(output logic [7:0] drive);
    logic [3:0] nib_a;
    logic [3:0] nib_b;
    for (int m = 0; m < 2; m++) tick_motor(m);
    for (int m = 0; m < 2; m++) begin
      if (!regs.adaptive_torque) one_coil[m] = 1'b0;
      else if (!one_coil[m] && cur_per[m] < regs.low_torque_speed) one_coil[m] = 1'b1;
      else if (one_coil[m] && cur_per[m] >= regs.low_torque_speed) one_coil[m] = 1'b0;
    end
    nib_a = coil_nibble(phase[0], one_coil[0]);
    nib_b = coil_nibble(phase[1], one_coil[1]);
    if (regs.release_when_stopped && cur_per[0] == STOP_PERIOD && cur_per[1] == STOP_PERIOD)
      drive = 8'h00;
    else
      drive = {nib_b, nib_a[0], nib_a[1], nib_a[2], nib_a[3]};
  endtask

  always @(posedge clk) begin : watch
    logic [7:0] drive;
    if (!rst_n) begin
      reset_motors();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (coil_drive_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("coil drive word %02h arrived with none expected",
                                         out_tdata);
        end else begin
          drive = coil_drive_q.pop_front();
          if (out_tdata !== drive) begin
            fail_count++;
            if (fail_count <= 10) $display("coil_drive mismatch: expected %02h, actual %02h",
                                           drive, out_tdata);
          end
        end
      end
      if (cfg_we) write_register(cfg_addr, cfg_wdata);
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_SET_SPEED) begin
          apply_speed(0, in_tdata[7:0]);
          apply_speed(1, in_tdata[15:8]);
        end else begin
          predict_tick(drive);
          coil_drive_q.push_back(drive);
        end
      end
    end
    pending = coil_drive_q.size();
  end

endmodule

// ----- verif/dual_stepper_ramp_controller_top_tb.sv -----
// Testbench top for the stepper controller: clock, reset, stimulus, settings and verdict.
`timescale 1ns / 1ps

module dual_stepper_ramp_controller_top_tb;
  import dsrc_pkg::*;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [7:0]  out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [7:0]  cfg_wdata = '0;

  int                fail_count;
  int                pending;
  int                send_gap_pct = 0;
  int                recv_stall_pct = 0;
  logic signed [7:0] last_a = '0;
  logic signed [7:0] last_b = '0;

  dual_stepper_ramp_controller_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  dual_stepper_ramp_controller_checker coil_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_word(input cmd_t cmd, input logic [7:0] a, input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {b, a};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] accel, input logic [7:0] low,
                                input logic adapt, input logic [2:0] maxp,
                                input logic [2:0] minp, input logic rel);
    write_reg(REG_MIN_PHASE, 8'(MIN_PHASE_RST));
    write_reg(REG_MAX_PHASE, 8'(maxp));
    write_reg(REG_MIN_PHASE, 8'(minp));
    write_reg(REG_ACCEL_PERIOD, accel);
    write_reg(REG_LOW_TORQUE, low);
    write_reg(REG_ADAPTIVE, 8'(adapt));
    write_reg(REG_RELEASE, 8'(rel));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_speed(input logic signed [7:0] prev);
    int pick;
    pick = $urandom_range(9);
    if (pick < 2) begin
      case ($urandom_range(4))
        0: return 8'h7F;
        1: return 8'h80;
        2: return 8'h00;
        3: return 8'h01;
        default: return 8'hFF;
      endcase
    end
    if (pick < 7) begin
      if (prev > 0) return 8'($urandom_range(127, 64));
      return 8'(0 - $urandom_range(128, 64));
    end
    return 8'($urandom);
  endfunction

  task automatic run_segment(input int count);
    logic [7:0] a;
    logic [7:0] b;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) drain();
      if ($urandom_range(99) < 10) begin
        a = rand_speed(last_a);
        b = rand_speed(last_b);
        last_a = a;
        last_b = b;
        send_word(CMD_SET_SPEED, a, b);
      end else begin
        send_word(CMD_TICK, 8'($urandom), 8'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    logic [2:0] top_phase;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(CMD_TICK, 8'h00, 8'h00);
    send_word(CMD_SET_SPEED, 8'h7F, 8'h80);
    repeat (3) send_word(CMD_TICK, 8'hFF, 8'hFF);
    send_word(CMD_SET_SPEED, 8'h00, 8'h00);
    send_word(CMD_TICK, 8'h00, 8'h00);
    send_word(CMD_SET_SPEED, 8'hFF, 8'h01);
    repeat (2) send_word(CMD_TICK, 8'h00, 8'h00);
    send_word(CMD_SET_SPEED, 8'h01, 8'hFF);
    send_word(CMD_TICK, 8'h00, 8'h00);
    send_word(CMD_SET_SPEED, 8'h80, 8'h7F);
    repeat (4) send_word(CMD_TICK, 8'h00, 8'h00);
    send_word(CMD_SET_SPEED, 8'h00, 8'h7F);
    repeat (2) send_word(CMD_TICK, 8'h00, 8'h00);
    drain();

    for (int seg = 0; seg < 5; seg++) begin
      case (seg)
        0: apply_settings(8'd1, 8'd255, 1'b1, 3'd4, 3'd1, 1'b1);
        1: apply_settings(8'd2, 8'd60, 1'b1, 3'd3, 3'd2, 1'b0);
        2: begin
          // Out-of-order phase bounds and unmapped indexes must leave the settings alone.
          write_reg(REG_MAX_PHASE, 8'd1);
          write_reg(REG_MIN_PHASE, 8'd4);
          write_reg(REG_SPARE_LO, 8'hFF);
          write_reg(REG_SPARE_HI, 8'h00);
          cfg_we <= 1'b0;
          @(negedge clk);
          apply_settings(8'd255, 8'd0, 1'b1, 3'd1, 3'd1, 1'b1);
        end
        3: apply_settings(8'd0, 8'd128, 1'b1, 3'd2, 3'd1, 1'b0);
        default: begin
          top_phase = 3'($urandom_range(4, 1));
          apply_settings(8'($urandom_range(8, 1)), 8'($urandom), 1'($urandom), top_phase,
                         3'($urandom_range(top_phase, 1)), 1'($urandom));
        end
      endcase
      case (seg % 4)
        0: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct   = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct   = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_gap_pct   = 15;
          recv_stall_pct = 15;
        end
      endcase
      run_segment((seg == 0) ? 80 : 75);
    end

    recv_stall_pct = 0;
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
